// ===== rtl/pcrm_pkg.sv =====
// ---------------------------------------------------------------------------
// pcrm_pkg: shared constants for the page compaction rank map
// Field widths, item kind codes, status codes and parameter defaults.
// ---------------------------------------------------------------------------
package pcrm_pkg;

    // Field widths fixed by the interface.
    localparam int PAGE_W   = 14;
    localparam int COUNT_W  = 15;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Parameter defaults.
    localparam int DEF_BLOCK_BITS = 64;
    localparam int DEF_NUM_BLOCKS = 256;

    // Page count after reset.
    localparam logic [COUNT_W-1:0] NUM_PAGES_RESET = 15'd16384;
    // Largest value a count field can hold.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    // Item kinds.
    localparam logic [KIND_W-1:0] K_CLEAR     = 2'd0;
    localparam logic [KIND_W-1:0] K_MARK      = 2'd1;
    localparam logic [KIND_W-1:0] K_FINALIZE  = 2'd2;
    localparam logic [KIND_W-1:0] K_TRANSLATE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;

endpackage

// ===== rtl/pcrm_ram.sv =====
// ---------------------------------------------------------------------------
// pcrm_ram: single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle; read data holds when idle.
// ---------------------------------------------------------------------------
module pcrm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pcrm_blk_div.sv =====
// ---------------------------------------------------------------------------
// pcrm_blk_div: page number to block index and bit offset
// Two registered stages: a reciprocal multiply gives the block index, then
// a multiply back and subtract gives the offset inside the block.
// ---------------------------------------------------------------------------
module pcrm_blk_div
    import pcrm_pkg::*;
#(
    parameter int BLOCK_BITS = DEF_BLOCK_BITS,
    parameter int OFF_W      = $clog2(BLOCK_BITS)
) (
    input  logic              i_clk,
    input  logic [PAGE_W-1:0] i_page,
    output logic [PAGE_W-1:0] o_block,
    output logic [OFF_W-1:0]  o_offset
);

    // Reciprocal exact for every page below 2**PAGE_W.
    localparam int    SHIFT = PAGE_W + OFF_W;
    localparam longint RECIP = ((longint'(1) << SHIFT) / BLOCK_BITS) + 1;
    localparam logic [PAGE_W+1:0] RECIP_V = RECIP[PAGE_W+1:0];
    localparam logic [PAGE_W-1:0] BB_V    = PAGE_W'(BLOCK_BITS);

    logic [2*PAGE_W+1:0] quot_prod;
    logic [2*PAGE_W+1:0] quot_shift;
    logic [2*PAGE_W-1:0] back_prod;
    logic [PAGE_W-1:0]   rem_full;
    logic [PAGE_W-1:0]   r_block;
    logic [OFF_W-1:0]    r_offset;

    // Stage one: block index by multiplying with the reciprocal.
    assign quot_prod  = {{(PAGE_W+2){1'b0}}, i_page} * {{PAGE_W{1'b0}}, RECIP_V};
    assign quot_shift = quot_prod >> SHIFT;

    always_ff @(posedge i_clk) begin
        r_block <= quot_shift[PAGE_W-1:0];
    end

    // Stage two: the remainder is below one block, so its low bits suffice.
    assign back_prod = {{PAGE_W{1'b0}}, r_block} * {{PAGE_W{1'b0}}, BB_V};
    assign rem_full  = i_page - back_prod[PAGE_W-1:0];

    always_ff @(posedge i_clk) begin
        r_offset <= rem_full[OFF_W-1:0];
    end

    assign o_block  = r_block;
    assign o_offset = r_offset;

endmodule

// ===== rtl/page_compaction_rank_map.sv =====
// ---------------------------------------------------------------------------
// page_compaction_rank_map: live-page bitmap with per-block prefix counts
// Maps original page numbers to compacted page numbers through a bitmap
// memory and a block base memory.
// ---------------------------------------------------------------------------
//
//  channel   direction  signals                              payload
//  --------  ---------  -----------------------------------  -------------------------
//  input     in         i_valid / o_ready                    i_kind, i_page_index
//  result    out        o_valid / i_ready                    o_compact_index, o_status
//  config    in         i_cfg_valid / o_cfg_ready            i_cfg_data (num_pages)
//
// One item is worked at a time. Mark steps through S_QUOT, S_REM, S_RD and
// S_MK_WR, and translate through S_QUOT, S_REM, S_RD, S_TR_CT and S_TR_AD,
// before S_DONE; a rejected item goes straight to S_DONE; finalize pairs S_F_RD
// with S_F_AC per block in use. Clear, and the pass after reset with o_ready
// low, zero all NUM_BLOCKS bitmap words; config writes are taken throughout.
// A new item is accepted while the previous result still waits; a stalled
// result only holds the finishing item back from loading the result register.
// ---------------------------------------------------------------------------
module page_compaction_rank_map
    import pcrm_pkg::*;
#(
    parameter int BLOCK_BITS = DEF_BLOCK_BITS,
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [PAGE_W-1:0]   i_page_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [COUNT_W-1:0]  o_compact_index,
    output logic [STATUS_W-1:0] o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data
);

    localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W  = $clog2(BLOCK_BITS);
    localparam int CNT_W  = $clog2(BLOCK_BITS + 1);
    localparam longint CAP_PAGES = longint'(NUM_BLOCKS) * longint'(BLOCK_BITS);
    localparam logic [ADDR_W-1:0] LAST_BLOCK = ADDR_W'(NUM_BLOCKS - 1);
    localparam logic [15:0] BB_STEP = 16'(BLOCK_BITS);

    // State codes.
    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_QUOT  = 4'd3;
    localparam logic [3:0] S_REM   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_MK_WR = 4'd6;
    localparam logic [3:0] S_TR_CT = 4'd7;
    localparam logic [3:0] S_TR_AD = 4'd8;
    localparam logic [3:0] S_F_RD  = 4'd9;
    localparam logic [3:0] S_F_AC  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // Registers.
    logic [3:0]            r_state;
    logic [ADDR_W-1:0]     r_addr;
    logic [15:0]           r_start;
    logic [COUNT_W-1:0]    r_total;
    logic [CNT_W-1:0]      r_cnt;
    logic [KIND_W-1:0]     r_kind;
    logic [PAGE_W-1:0]     r_page;
    logic [COUNT_W-1:0]    r_res_index;
    logic [STATUS_W-1:0]   r_res_status;
    logic [COUNT_W-1:0]    r_num_pages;
    logic                  r_bases_valid;
    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_out_index;
    logic [STATUS_W-1:0]   r_out_status;

    // Memory ports and helpers.
    logic                  live_we;
    logic [ADDR_W-1:0]     live_waddr;
    logic [BLOCK_BITS-1:0] live_wdata;
    logic                  live_re;
    logic [ADDR_W-1:0]     live_raddr;
    logic [BLOCK_BITS-1:0] live_rdata;
    logic                  base_we;
    logic                  base_re;
    logic [COUNT_W-1:0]    base_rdata;
    logic [PAGE_W-1:0]     div_block;
    logic [OFF_W-1:0]      div_offset;
    logic [COUNT_W-1:0]    used;
    logic                  in_accept;
    logic                  page_out;
    logic                  out_free;
    logic                  fin_walk;
    logic [BLOCK_BITS-1:0] below_mask;
    logic [BLOCK_BITS-1:0] page_bit;
    logic [15:0]           fin_sum;
    logic [15:0]           tr_sum;

    function automatic logic [CNT_W-1:0] popcnt(input logic [BLOCK_BITS-1:0] v);
        logic [CNT_W-1:0] s;
        s = '0;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            s = s + CNT_W'(v[i]);
        end
        return s;
    endfunction

    // Pages in use: the register clipped to the capacity.
    always_comb begin
        if (longint'(r_num_pages) > CAP_PAGES) begin
            used = CAP_PAGES[COUNT_W-1:0];
        end else begin
            used = r_num_pages;
        end
    end

    assign in_accept = i_valid && o_ready;
    assign page_out  = ({1'b0, i_page_index} >= used);
    assign out_free  = !r_out_valid || i_ready;
    assign fin_walk  = (r_start < {1'b0, used});
    assign page_bit  = {{(BLOCK_BITS-1){1'b0}}, 1'b1} << div_offset;
    assign below_mask = page_bit - {{(BLOCK_BITS-1){1'b0}}, 1'b1};
    assign fin_sum   = {1'b0, r_total} + 16'(popcnt(live_rdata));
    assign tr_sum    = {1'b0, base_rdata} + 16'(r_cnt);

    // Block index and offset of the held page.
    pcrm_blk_div #(
        .BLOCK_BITS (BLOCK_BITS),
        .OFF_W      (OFF_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_page   (r_page),
        .o_block  (div_block),
        .o_offset (div_offset)
    );

    // Bitmap memory port control.
    always_comb begin
        live_we    = 1'b0;
        live_waddr = r_addr;
        live_wdata = '0;
        live_re    = 1'b0;
        live_raddr = r_addr;
        unique case (r_state) inside
            S_INIT, S_CLR: begin
                live_we = 1'b1;
            end
            S_RD: begin
                live_re    = 1'b1;
                live_raddr = div_block[ADDR_W-1:0];
            end
            S_MK_WR: begin
                live_we    = 1'b1;
                live_waddr = div_block[ADDR_W-1:0];
                live_wdata = live_rdata | page_bit;
            end
            S_F_RD: begin
                live_re = fin_walk;
            end
            default: begin
            end
        endcase
    end

    assign base_we = (r_state == S_F_RD) && fin_walk;
    assign base_re = (r_state == S_RD);

    pcrm_ram #(
        .WIDTH  (BLOCK_BITS),
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (ADDR_W)
    ) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (live_we),
        .i_waddr (live_waddr),
        .i_wdata (live_wdata),
        .i_re    (live_re),
        .i_raddr (live_raddr),
        .o_rdata (live_rdata)
    );

    pcrm_ram #(
        .WIDTH  (COUNT_W),
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (ADDR_W)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (base_we),
        .i_waddr (r_addr),
        .i_wdata (r_total),
        .i_re    (base_re),
        .i_raddr (div_block[ADDR_W-1:0]),
        .o_rdata (base_rdata)
    );

    // Sequencer: one item from acceptance to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_addr        <= '0;
            r_bases_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_BLOCK) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_kind       <= i_kind;
                        r_page       <= i_page_index;
                        r_res_index  <= '0;
                        r_res_status <= ST_OK;
                        r_addr       <= '0;
                        r_start      <= '0;
                        r_total      <= '0;
                        case (i_kind)
                            K_CLEAR: begin
                                r_bases_valid <= 1'b0;
                                r_state       <= S_CLR;
                            end
                            K_FINALIZE: begin
                                r_state <= S_F_RD;
                            end
                            default: begin
                                if (page_out) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_DONE;
                                end else if (i_kind == K_TRANSLATE && !r_bases_valid) begin
                                    r_res_status <= ST_NOT_READY;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_QUOT;
                                end
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_BLOCK) begin
                        r_state <= S_DONE;
                    end
                end
                S_QUOT: begin
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= (r_kind == K_MARK) ? S_MK_WR : S_TR_CT;
                end
                S_MK_WR: begin
                    r_state <= S_DONE;
                end
                S_TR_CT: begin
                    r_cnt   <= popcnt(live_rdata & below_mask);
                    r_state <= S_TR_AD;
                end
                S_TR_AD: begin
                    r_res_index <= tr_sum[15] ? COUNT_MAX : tr_sum[COUNT_W-1:0];
                    r_state     <= S_DONE;
                end
                S_F_RD: begin
                    if (fin_walk) begin
                        r_state <= S_F_AC;
                    end else begin
                        r_res_index   <= r_total;
                        r_bases_valid <= 1'b1;
                        r_state       <= S_DONE;
                    end
                end
                S_F_AC: begin
                    r_total <= fin_sum[15] ? COUNT_MAX : fin_sum[COUNT_W-1:0];
                    r_addr  <= r_addr + 1'b1;
                    r_start <= r_start + BB_STEP;
                    r_state <= S_F_RD;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // A register write invalidates the bases; it wins over finalize.
            if (i_cfg_valid) begin
                r_bases_valid <= 1'b0;
            end
        end
    end

    // Page count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_pages <= NUM_PAGES_RESET;
        end else if (i_cfg_valid) begin
            r_num_pages <= i_cfg_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_index  <= r_res_index;
                r_out_status <= r_res_status;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_compact_index = r_out_index;
    assign o_status        = r_out_status;

    // A bitmap block written by mark always lies inside the memory.
    a_mark_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MK_WR) |-> (32'(div_block) < 32'(NUM_BLOCKS)))
        else $error("mark writes outside the bitmap memory");

    // Not ready and out of range results carry a zero index.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_status != ST_OK) |-> (o_compact_index == '0))
        else $error("error result with nonzero index");

    // A register write leaves the bases invalid.
    a_cfg_inval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !r_bases_valid)
        else $error("bases still valid after a register write");

    // A result appears only from the finishing state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the finishing state");

endmodule
